@@ hdl/multiplexed_rgb_led_pwm_scanner_core_defines.svh @@
// ----------------------------------------------------------------------------
// LED PWM scanner assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MULTIPLEXED_RGB_LED_PWM_SCANNER_CORE_DEFINES_SVH
`define MULTIPLEXED_RGB_LED_PWM_SCANNER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MRLPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define MRLPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MRLPS_ASSERT_NOW(label, clk, rst, ante, cons)
`define MRLPS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hdl/mrlps_pkg.sv @@
// ----------------------------------------------------------------------------
// LED PWM scanner package
// Shared constants and codes for the multiplexed RGB LED PWM scanner.
// ----------------------------------------------------------------------------
package mrlps_pkg;

   localparam int DEFAULT_BRIGHTNESS_LEVELS = 32;
   localparam int DEFAULT_NUM_LEDS          = 12;

   localparam int NUM_GROUPS  = 6;
   localparam int NUM_COLORS  = 3;
   localparam int GROUP_LANES = 2 * NUM_COLORS;
   localparam int LEVEL_W     = 8;
   localparam int MASK_W      = 12;
   localparam int GROUP_W     = 3;

   localparam logic [MASK_W-1:0] MASK_RESET = 12'hFFF;

   // command codes (req_tuser)
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // color codes
   localparam logic [1:0] COLOR_RED   = 2'd0;
   localparam logic [1:0] COLOR_GREEN = 2'd1;
   localparam logic [1:0] COLOR_BLUE  = 2'd2;
   localparam logic [1:0] COLOR_NONE  = 2'd3;

   // register indexes
   localparam logic CSR_LED_ENABLE_MASK = 1'b0;
   localparam logic CSR_SCAN_ENABLE     = 1'b1;

   localparam logic [GROUP_W-1:0] LAST_GROUP = GROUP_W'(NUM_GROUPS - 1);

endpackage

@@ hdl/multiplexed_rgb_led_pwm_scanner_core.sv @@
// ----------------------------------------------------------------------------
// Multiplexed RGB LED PWM scanner core
// Holds RGB levels for a set of LEDs and produces one scan slot per tick.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries commands: tuser 0 writes one level (led_index, color,
//   level in tdata) and returns nothing; tuser 1 is a scan tick that returns
//   one slot on rsp_* (cathode select and two 3-bit color groups in tdata,
//   frame end on tlast).
//   csr_* writes led_enable_mask (index 0) and scan_enable (index 1); write
//   only while no tick is in flight.
//   Pipeline: a tick is captured in the stage register at its accept edge,
//   then in the result register when it can advance. The level store row
//   for the active group is read at the accept edge; the compare against
//   the PWM level counter sits between the stage and result registers.
//   Throughput: one item per cycle unless rsp_* back-pressure stalls; a
//   level write followed by a tick in the next cycle sees the new level.
//   Reset: level store reads as zero (per-entry valid bits), counters go to
//   zero, mask to all ones, scan disabled.
//   Stall: with rsp_tready low the result register holds, one more tick
//   waits in the stage register, then req_tready drops. Level writes are
//   taken whenever req_tready is high.
// ----------------------------------------------------------------------------
`include "multiplexed_rgb_led_pwm_scanner_core_defines.svh"

module multiplexed_rgb_led_pwm_scanner_core
   import mrlps_pkg::*;
#(
   parameter int BRIGHTNESS_LEVELS = DEFAULT_BRIGHTNESS_LEVELS,
   parameter int NUM_LEDS          = DEFAULT_NUM_LEDS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,  // led_index[3:0], color[5:4], level[13:6]
   input  logic                req_tuser,  // command
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,  // cathode_select[5:0], port_a[8:6], port_b[11:9]
   output logic                rsp_tlast,  // frame_end
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [MASK_W-1:0]   csr_wdata
);

   localparam int ROWS_RAW = (NUM_LEDS + 1) / 2;
   localparam int ROWS     = (ROWS_RAW < NUM_GROUPS) ? ROWS_RAW : NUM_GROUPS;
   localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int LVL_W    = $clog2(BRIGHTNESS_LEVELS);
   localparam logic [LVL_W-1:0] LAST_LEVEL = LVL_W'(BRIGHTNESS_LEVELS - 1);

   // configuration
   logic [MASK_W-1:0]  mask_ff;
   logic               scan_en_ff;

   // scan counters
   logic [GROUP_W-1:0] group_ff, group_in;
   logic [LVL_W-1:0]   level_ff, level_in;

   // level store: one row per group, lanes {B1,G1,R1,B0,G0,R0}
   logic [LEVEL_W-1:0]     mem_ff [ROWS][GROUP_LANES];
   logic [GROUP_LANES-1:0] vld_ff [ROWS];

   // stage register (ticks only)
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_scan_ff;
   logic [GROUP_W-1:0]     s1_group_ff;
   logic [LVL_W-1:0]       s1_level_ff;
   logic                   s1_last_ff;
   logic [1:0]             s1_mask_ff;
   logic [GROUP_LANES-1:0] s1_vld_ff;
   logic [LEVEL_W-1:0]     s1_row_ff [GROUP_LANES];

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [11:0] rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   logic                 req_acc, tick_acc, s1_adv;
   logic                 last_level, row_ok;
   logic [ROW_W-1:0]     rd_row;
   logic [1:0]           mask_pair;
   logic [3:0]           wr_led;
   logic [1:0]           wr_color;
   logic [LEVEL_W-1:0]   wr_level;
   logic                 wr_ok;
   logic [ROW_W-1:0]     wr_row;
   logic [2:0]           wr_lane;
   logic [2:0]           colors_a, colors_b;

   // ---------------- handshake ----------------
   assign s1_adv     = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_acc    = req_tvalid && req_tready;
   assign tick_acc   = req_acc && (req_tuser == CMD_TICK);

   // ---------------- counters ----------------
   assign last_level = (level_ff == LAST_LEVEL);

   always_comb begin
      group_in = group_ff;
      level_in = level_ff;
      if (tick_acc && scan_en_ff) begin
         if (group_ff == LAST_GROUP) begin
            group_in = '0;
            level_in = last_level ? '0 : level_ff + 1'b1;
         end else begin
            group_in = group_ff + 1'b1;
         end
      end
   end

   // ---------------- level store access ----------------
   assign row_ok    = ({1'b0, group_ff} < (GROUP_W + 1)'(ROWS));
   assign rd_row    = group_ff[ROW_W-1:0];
   assign mask_pair = 2'(mask_ff >> {group_ff, 1'b0});

   assign wr_led   = req_tdata[3:0];
   assign wr_color = req_tdata[5:4];
   assign wr_level = req_tdata[13:6];
   assign wr_row   = wr_led[ROW_W:1];
   assign wr_lane  = wr_led[0] ? (3'(wr_color) + 3'(NUM_COLORS)) : 3'(wr_color);
   // LEDs past the scanned groups are never visible, so their writes are dropped
   assign wr_ok    = req_acc && (req_tuser == CMD_WRITE)
                     && ({1'b0, wr_led} < 5'(NUM_LEDS))
                     && (wr_color != COLOR_NONE)
                     && ({1'b0, wr_led[3:1]} < 4'(ROWS));

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem_ff[wr_row][wr_lane] <= wr_level;
      end
      if (tick_acc) begin
         s1_row_ff <= mem_ff[rd_row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            vld_ff[r] <= '0;
         end
      end else if (wr_ok) begin
         vld_ff[wr_row][wr_lane] <= 1'b1;
      end
   end

   // ---------------- configuration and counters ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff    <= MASK_RESET;
         scan_en_ff <= 1'b0;
         group_ff   <= '0;
         level_ff   <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LED_ENABLE_MASK: mask_ff    <= csr_wdata;
               CSR_SCAN_ENABLE:     scan_en_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         group_ff <= group_in;
         level_ff <= level_in;
      end
   end

   // ---------------- stage register ----------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tready) begin
         s1_valid_in = tick_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_acc) begin
         s1_scan_ff  <= scan_en_ff;
         s1_group_ff <= group_ff;
         s1_level_ff <= level_ff;
         s1_last_ff  <= last_level && (group_ff == LAST_GROUP);
         s1_mask_ff  <= mask_pair;
         s1_vld_ff   <= row_ok ? vld_ff[rd_row] : '0;
      end
   end

   // ---------------- PWM compare ----------------
   always_comb begin
      for (int c = 0; c < NUM_COLORS; c++) begin
         colors_a[c] = s1_mask_ff[0] && s1_vld_ff[c]
                       && (LEVEL_W'(s1_level_ff) < s1_row_ff[c]);
         colors_b[c] = s1_mask_ff[1] && s1_vld_ff[c + NUM_COLORS]
                       && (LEVEL_W'(s1_level_ff) < s1_row_ff[c + NUM_COLORS]);
      end
      if (s1_scan_ff) begin
         rsp_data_in = {colors_b, colors_a, 6'(6'd1 << s1_group_ff)};
         rsp_last_in = s1_last_ff;
      end else begin
         rsp_data_in = '0;
         rsp_last_in = 1'b0;
      end
   end

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_valid_ff && s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

   // ---------------- assertions ----------------
   `MRLPS_ASSERT_NOW(a_group_range, clock, reset, 1'b1, group_ff <= LAST_GROUP)
   `MRLPS_ASSERT_NOW(a_select_onehot, clock, reset, rsp_tvalid,
                     $onehot0(rsp_tdata[5:0]))
   `MRLPS_ASSERT_NOW(a_frame_end_group, clock, reset, rsp_tvalid && rsp_tlast,
                     rsp_tdata[NUM_GROUPS-1])
   `MRLPS_ASSERT_NEXT(a_group_wrap, clock, reset,
                      tick_acc && scan_en_ff && (group_ff == LAST_GROUP),
                      group_ff == '0)

endmodule
